@@ hw/rtl/ird_pkg.sv @@
package ird_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  // request commands
  localparam logic [1:0] CMD_REMOVE = 2'd0;
  localparam logic [1:0] CMD_TRADE  = 2'd1;
  localparam logic [1:0] CMD_ADD    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_MINQTY = 2'd1;
  localparam logic [1:0] REG_TOL    = 2'd2;

  localparam logic [15:0] WINDOW_RST = 16'd500;
  localparam logic [31:0] MINQTY_RST = 32'd300;
  localparam logic [9:0]  TOL_RST    = 10'd10;

  // cell operations
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_PURGE  = 3'd1;
  localparam logic [2:0] OP_TRADE  = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_SWAP   = 3'd4;
  localparam logic [2:0] OP_APPEND = 3'd5;

  typedef struct packed {
    logic [31:0] price;
    logic [15:0] agent;
    logic [47:0] tstamp;
    logic        traded;
  } slot_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        phase;
    logic        full;
    logic [31:0] price;
    logic [9:0]  tol;
    logic [47:0] now;
    logic [17:0] thresh;
    slot_t       new_slot;
  } cell_ctl_t;

endpackage

@@ hw/rtl/iceberg_renewal_detector_top.sv @@
// Sequence: a trade or unknown command goes through DISPATCH back to idle; an add goes
// through DISPATCH and DECIDE, then idle with no match, else erases the match and runs
// odd-even compaction rounds; a remove drops stale entries, compacts, then appends the entry.
// The alert strobe is registered from DECIDE. One request at a time, next when busy drops.
// Reset (rst_n low, synchronous) empties the table and loads register defaults.
// Alerts are single-cycle strobes; the receiver cannot stall them.
module iceberg_renewal_detector_top #(
  parameter int TABLE_DEPTH = ird_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_price,
  input  logic [31:0] in_qty,
  input  logic [15:0] in_agent_id,
  input  logic [31:0] in_offer_id,
  input  logic [47:0] in_timestamp_ms,
  input  logic [15:0] in_age_ms,
  input  logic        in_was_traded,
  input  logic [15:0] in_ticker_id,
  output logic        out_valid,
  output logic        out_conviction,
  output logic [31:0] out_alert_price,
  output logic [31:0] out_alert_qty,
  output logic [15:0] out_alert_agent,
  output logic [31:0] out_alert_offer,
  output logic [15:0] out_alert_ticker,
  output logic [47:0] out_alert_time,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_DECIDE  = 3'd2;
  localparam logic [2:0] ST_COMPACT = 3'd3;
  localparam logic [2:0] ST_APPEND  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic        phase_r, phase_nxt;
  logic [15:0] win_r;
  logic [31:0] minqty_r;
  logic [9:0]  tol_r;

  logic [1:0]  cmd_r;
  logic [31:0] price_r, qty_r, offer_r;
  logic [15:0] agent_r, age_r, ticker_r;
  logic [47:0] now_r;
  logic        traded_r;

  logic        found_r;
  logic [15:0] sel_agent_r;
  logic [47:0] sel_time_r;
  logic        sel_traded_r;

  logic        ov_r, ov_nxt;
  logic        conv_r;

  ird_pkg::cell_ctl_t ctl;
  logic [TABLE_DEPTH-1:0] v, m, first;
  ird_pkg::slot_t         sd [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] inv;
  logic                   unpacked;
  logic [15:0]            f_agent;
  logic [47:0]            f_time;
  logic                   f_traded;
  logic [47:0]            elapsed;
  logic                   young, alert;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= ird_pkg::WINDOW_RST;
      minqty_r <= ird_pkg::MINQTY_RST;
      tol_r    <= ird_pkg::TOL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ird_pkg::REG_WINDOW: win_r    <= cfg_data[15:0];
        ird_pkg::REG_MINQTY: minqty_r <= cfg_data;
        ird_pkg::REG_TOL:    tol_r    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // latch request fields
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r    <= in_command;
      price_r  <= in_price;
      qty_r    <= in_qty;
      agent_r  <= in_agent_id;
      offer_r  <= in_offer_id;
      now_r    <= in_timestamp_ms;
      age_r    <= in_age_ms;
      traded_r <= in_was_traded;
      ticker_r <= in_ticker_id;
    end
  end

  // broadcast to the cell row
  always_comb begin
    ctl.op     = ird_pkg::OP_NOP;
    ctl.phase  = phase_r;
    ctl.full   = v[TABLE_DEPTH-1];
    ctl.price  = price_r;
    ctl.tol    = tol_r;
    ctl.now    = now_r;
    ctl.thresh = {2'd0, win_r} + {1'b0, win_r, 1'b0};
    ctl.new_slot.price  = price_r;
    ctl.new_slot.agent  = agent_r;
    ctl.new_slot.tstamp = now_r - {32'd0, age_r};
    ctl.new_slot.traded = traded_r;
    unique case (state_r)
      ST_DISPATCH: begin
        if (cmd_r == ird_pkg::CMD_REMOVE) ctl.op = ird_pkg::OP_PURGE;
        else if (cmd_r == ird_pkg::CMD_TRADE) ctl.op = ird_pkg::OP_TRADE;
      end
      ST_DECIDE:  if (found_r) ctl.op = ird_pkg::OP_ERASE;
      ST_COMPACT: if (unpacked) ctl.op = ird_pkg::OP_SWAP;
      ST_APPEND:  ctl.op = ird_pkg::OP_APPEND;
      default: ;
    endcase
  end

  // cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic           lv, rv;
    ird_pkg::slot_t ld, rd;
    if (i == 0) begin : g_l0
      assign lv = 1'b1;
      assign ld = '0;
    end else begin : g_ln
      assign lv = v[i-1];
      assign ld = sd[i-1];
    end
    if (i == TABLE_DEPTH-1) begin : g_rl
      assign rv = 1'b0;
      assign rd = '0;
      assign inv[i] = 1'b0;
    end else begin : g_rn
      assign rv = v[i+1];
      assign rd = sd[i+1];
      assign inv[i] = !v[i] && v[i+1];
    end
    ird_cell #(.IDX(i), .LAST(TABLE_DEPTH-1)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .left_valid(lv), .left_slot(ld),
      .right_valid(rv), .right_slot(rd),
      .valid(v[i]), .slot(sd[i]), .match(m[i])
    );
  end

  assign unpacked = |inv;

  // select oldest matching entry
  assign first = m & (~m + 1'b1);
  always_comb begin
    f_agent  = '0;
    f_time   = '0;
    f_traded = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      f_agent  = f_agent  | ({16{first[i]}} & sd[i].agent);
      f_time   = f_time   | ({48{first[i]}} & sd[i].tstamp);
      f_traded = f_traded | (first[i] & sd[i].traded);
    end
  end

  always_ff @(posedge clk) begin
    found_r      <= |m;
    sel_agent_r  <= f_agent;
    sel_time_r   <= f_time;
    sel_traded_r <= f_traded;
  end

  // add decision
  assign elapsed = now_r - sel_time_r;
  assign young   = $signed(elapsed) < $signed({32'd0, win_r});
  assign alert   = found_r && young && (qty_r >= minqty_r) && (sel_agent_r == agent_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    ov_nxt    = 1'b0;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        phase_nxt = 1'b0;
        if (cmd_r == ird_pkg::CMD_REMOVE) state_nxt = ST_COMPACT;
        else if (cmd_r == ird_pkg::CMD_ADD) state_nxt = ST_DECIDE;
        else state_nxt = ST_IDLE;
      end
      ST_DECIDE: begin
        ov_nxt    = alert;
        state_nxt = found_r ? ST_COMPACT : ST_IDLE;
      end
      ST_COMPACT: begin
        if (unpacked) begin
          phase_nxt = !phase_r;
        end else begin
          state_nxt = (cmd_r == ird_pkg::CMD_REMOVE) ? ST_APPEND : ST_IDLE;
        end
      end
      ST_APPEND: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DECIDE) conv_r <= sel_traded_r;
  end

  assign out_valid        = ov_r;
  assign out_conviction   = conv_r;
  assign out_alert_price  = price_r;
  assign out_alert_qty    = qty_r;
  assign out_alert_agent  = agent_r;
  assign out_alert_offer  = offer_r;
  assign out_alert_ticker = ticker_r;
  assign out_alert_time   = now_r;

endmodule

@@ hw/rtl/ird_cell.sv @@
module ird_cell #(
  parameter int IDX  = 0,
  parameter int LAST = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ird_pkg::cell_ctl_t ctl,
  input  logic              left_valid,
  input  ird_pkg::slot_t    left_slot,
  input  logic              right_valid,
  input  ird_pkg::slot_t    right_slot,
  output logic              valid,
  output ird_pkg::slot_t    slot,
  output logic              match
);

  localparam logic PAR = 1'(IDX % 2);
  localparam bit IS_LAST = (IDX == LAST);

  logic           valid_r, valid_nxt;
  ird_pkg::slot_t slot_r, slot_nxt;
  logic [31:0]    pdiff;
  logic [47:0]    tdiff;
  logic           stale;

  // price distance and age against broadcast request
  assign pdiff = (ctl.price >= slot_r.price) ? ctl.price - slot_r.price
                                             : slot_r.price - ctl.price;
  assign match = valid_r && (pdiff < {22'd0, ctl.tol});
  assign tdiff = ctl.now - slot_r.tstamp;
  assign stale = $signed(tdiff) > $signed({30'd0, ctl.thresh});

  // apply operation
  always_comb begin
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    unique case (ctl.op)
      ird_pkg::OP_PURGE: if (stale) valid_nxt = 1'b0;
      ird_pkg::OP_TRADE: if (match) slot_nxt.traded = 1'b1;
      ird_pkg::OP_ERASE: if (match) valid_nxt = 1'b0;
      ird_pkg::OP_SWAP: begin
        if (PAR == ctl.phase) begin
          if (!valid_r && right_valid) begin
            valid_nxt = 1'b1;
            slot_nxt  = right_slot;
          end
        end else if (IDX > 0) begin
          if (!left_valid && valid_r) begin
            valid_nxt = 1'b0;
            slot_nxt  = left_slot;
          end
        end
      end
      ird_pkg::OP_APPEND: begin
        if (ctl.full) begin
          valid_nxt = 1'b1;
          slot_nxt  = IS_LAST ? ctl.new_slot : right_slot;
        end else if (!valid_r && left_valid) begin
          valid_nxt = 1'b1;
          slot_nxt  = ctl.new_slot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign valid = valid_r;
  assign slot  = slot_r;

endmodule

@@ hw/rtl/ird_checker.sv @@
module ird_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // accepted request keeps the block busy next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after request");

  // alert strobe comes only while busy
  a_alert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("alert while idle");

  // alert is a single-cycle strobe
  a_alert_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("alert held over two cycles");

  // reset clears the strobe
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("alert after reset");

endmodule

bind iceberg_renewal_detector_top ird_checker u_ird_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);
